// ===== src/hed_pkg.sv =====
// Package for the exact division stream unit: register indexes and state codes.
// Used by the top level and the serial multiplier; no dependencies.
package hed_pkg;

	localparam logic [2:0] REG_TWO_LIMB_MODE = 3'd0;
	localparam logic [2:0] REG_DIVISOR_LOW   = 3'd1;
	localparam logic [2:0] REG_DIVISOR_HIGH  = 3'd2;
	localparam logic [2:0] REG_INVERSE_LOW   = 3'd3;
	localparam logic [2:0] REG_INVERSE_HIGH  = 3'd4;

	localparam int unsigned CFG_INDEX_BITS = 3;

	typedef logic [1:0] hed_state_t;

	localparam hed_state_t S_IDLE = 2'd0;
	localparam hed_state_t S_MUL1 = 2'd1;
	localparam hed_state_t S_MUL2 = 2'd2;
	localparam hed_state_t S_OUT  = 2'd3;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} hed_mul_ctl_t;

endpackage

// ===== src/hed_serial_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle, full product.
// Depends on hed_pkg for the control struct.
module hed_serial_mul import hed_pkg::*; #(
	parameter int unsigned WIDTH = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [WIDTH-1:0]       a,
	input  logic [WIDTH-1:0]       b,
	output hed_mul_ctl_t           ctl,
	output logic [2*WIDTH-1:0]     prod
);

	localparam int unsigned CNT_BITS = $clog2(WIDTH);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WIDTH - 1);

	logic [WIDTH:0]      hi_q;
	logic [WIDTH-1:0]    lo_q;
	logic [WIDTH-1:0]    a_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [WIDTH:0]      sum;

	assign sum = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			lo_q <= b;
			hi_q <= '0;
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[WIDTH:1]};
			lo_q <= {sum[0], lo_q[WIDTH-1:1]};
		end
	end

	assign prod      = {hi_q[WIDTH-1:0], lo_q};
	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;

endmodule

// ===== src/hensel_exact_division_stream_unit.sv =====
// Hensel exact division by an odd divisor over a stream of numerator items.
// Depends on hed_pkg and hed_serial_mul.
//
// Usage:
//   Input channel (in_valid / in_stall): word_low, word_high, final_item,
//   least significant item first. Output channel (out_valid / out_stall):
//   quotient_low, quotient_high, final_result, not_exact, one item per input.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; write it only while the block is idle.
//   Each item goes through two serial multiplications at twice the limb
//   width, one multiplier bit per cycle, and one item at a time; the next
//   item is taken only after the result is loaded into the output register.
//   The shift-add multiplier sets the pace.
//   A finished result waits in the output register while out_stall is high;
//   the next item is taken meanwhile and its result is held back until the
//   register frees. Reset clears the carry, restores the register defaults
//   (one-limb mode, divisor 1, inverse 1) and empties the output.
//   After a final item the carry returns to zero.
module hensel_exact_division_stream_unit import hed_pkg::*; #(
	parameter int unsigned LIMB_BITS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [LIMB_BITS-1:0]      word_low,
	input  logic [LIMB_BITS-1:0]      word_high,
	input  logic                      final_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [LIMB_BITS-1:0]      quotient_low,
	output logic [LIMB_BITS-1:0]      quotient_high,
	output logic                      final_result,
	output logic                      not_exact,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [LIMB_BITS-1:0]      cfg_data
);

	localparam int unsigned N = 2 * LIMB_BITS;

	hed_state_t state_q;
	logic                 mode_q;
	logic [LIMB_BITS-1:0] div_lo_q, div_hi_q, inv_lo_q, inv_hi_q;
	logic [N-1:0]         carry_q;
	logic                 borrow_q, fin_q, imode_q;
	logic [N-1:0]         quot_q;

	logic                 accept;
	logic [N-1:0]         src, cin, diff;
	logic                 borrow;
	logic                 mul_start;
	logic [N-1:0]         mul_a, mul_b;
	hed_mul_ctl_t         mul_ctl;
	logic [2*N-1:0]       prod;
	logic [N-1:0]         qval, phigh, next_carry;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	always_comb begin
		if (mode_q) begin
			src  = {word_high, word_low};
			cin  = carry_q;
		end else begin
			src  = {{LIMB_BITS{1'b0}}, word_low};
			cin  = {{LIMB_BITS{1'b0}}, carry_q[LIMB_BITS-1:0]};
		end
		diff   = src - cin;
		borrow = cin > src;
		if (!mode_q)
			diff[N-1:LIMB_BITS] = '0;
	end

	assign qval = imode_q ? prod[N-1:0] : {{LIMB_BITS{1'b0}}, prod[LIMB_BITS-1:0]};

	always_comb begin
		mul_start = 1'b0;
		mul_a     = imode_q ? {div_hi_q, div_lo_q} : {{LIMB_BITS{1'b0}}, div_lo_q};
		mul_b     = qval;
		if (accept) begin
			mul_start = 1'b1;
			mul_a     = mode_q ? {inv_hi_q, inv_lo_q} : {{LIMB_BITS{1'b0}}, inv_lo_q};
			mul_b     = diff;
		end else if (state_q == S_MUL1 && mul_ctl.done) begin
			mul_start = 1'b1;
		end
	end

	hed_serial_mul #(.WIDTH(N)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.ctl    (mul_ctl),
		.prod   (prod)
	);

	always_comb begin
		if (imode_q) begin
			phigh      = prod[2*N-1:N];
			next_carry = phigh + {{(N-1){1'b0}}, borrow_q};
		end else begin
			phigh      = {{LIMB_BITS{1'b0}}, prod[N-1:LIMB_BITS]};
			next_carry = {{LIMB_BITS{1'b0}},
				phigh[LIMB_BITS-1:0] + {{(LIMB_BITS-1){1'b0}}, borrow_q}};
		end
		if (fin_q)
			next_carry = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			carry_q   <= '0;
			mode_q    <= 1'b0;
			div_lo_q  <= {{(LIMB_BITS-1){1'b0}}, 1'b1};
			div_hi_q  <= '0;
			inv_lo_q  <= {{(LIMB_BITS-1){1'b0}}, 1'b1};
			inv_hi_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TWO_LIMB_MODE: mode_q   <= cfg_data[0];
					REG_DIVISOR_LOW:   div_lo_q <= cfg_data;
					REG_DIVISOR_HIGH:  div_hi_q <= cfg_data;
					REG_INVERSE_LOW:   inv_lo_q <= cfg_data;
					REG_INVERSE_HIGH:  inv_hi_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_MUL1;
				end
				S_MUL1: begin
					if (mul_ctl.done)
						state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (mul_ctl.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						carry_q   <= next_carry;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			borrow_q <= borrow;
			fin_q    <= final_item;
			imode_q  <= mode_q;
		end
		if (state_q == S_MUL1 && mul_ctl.done)
			quot_q <= qval;
		if (state_q == S_OUT && out_free) begin
			quotient_low  <= quot_q[LIMB_BITS-1:0];
			quotient_high <= quot_q[N-1:LIMB_BITS];
			final_result  <= fin_q;
			not_exact     <= fin_q & borrow_q;
		end
	end

`ifndef SYNTHESIS
	a_idle_no_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mul_ctl.busy)
		else $error("multiplier busy while idle");
	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result shown outside output state");
	a_mul_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1 || state_q == S_MUL2) && !mul_ctl.done |-> mul_ctl.busy)
		else $error("multiplier stopped early");
	a_carry_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free && fin_q) |=> (carry_q == '0))
		else $error("carry not cleared after final item");
`endif

endmodule
